### design/isu_pkg.sv
// shared types and constants for the interval set union block
`default_nettype none
package isu_pkg;

   localparam logic [1:0] MODE_INCLUDE = 2'd0;
   localparam logic [1:0] MODE_LOOKUP  = 2'd1;
   localparam logic [1:0] MODE_INVERT  = 2'd2;

   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] range_low;
      logic signed [31:0] range_high;
      logic signed [31:0] probe_value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [3:0]         hit_index;
      logic signed [31:0] smallest;
      logic signed [31:0] largest;
      logic [31:0]        element_count;
      logic [4:0]         interval_count;
      logic               overflow;
   } rsp_type;

endpackage
`default_nettype wire

### design/isu_front.sv
// request intake: two-entry queue holding accepted requests for the engine
`default_nettype none
module isu_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   output logic                 req_full,
   input  wire isu_pkg::req_type req_data,
   output logic                 cmd_valid,
   input  wire logic            cmd_take,
   output isu_pkg::req_type     cmd_data
);

   isu_pkg::req_type buf_ff [2];
   logic       rd_ptr_ff, wr_ptr_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = buf_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_take && cmd_valid;

   // storage write
   always_ff @(posedge clock) begin
      if (do_push) buf_ff[wr_ptr_ff] <= req_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

`ifndef SYNTHESIS
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("intake queue overfilled");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      req_full |-> cmd_valid) else $error("full queue reports no request");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("fill count missed a push");
`endif

endmodule
`default_nettype wire

### design/isu_engine.sv
// set engine: interval store, per-request sweep, status and result register
`default_nettype none
module isu_engine #(
   parameter int MAX_INTERVALS = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            cmd_valid,
   output logic                 cmd_take,
   input  wire isu_pkg::req_type cmd_data,
   output logic                 rsp_empty,
   input  wire logic            rsp_pop,
   output isu_pkg::rsp_type     rsp_data
);

   localparam int IW = $clog2(MAX_INTERVALS);
   localparam int CW = $clog2(MAX_INTERVALS + 2);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_STAT = 3'd2;
   localparam logic [2:0] ST_DONE = 3'd3;

   // live and scratch stores, bank selects which is live
   logic signed [31:0] st_ff [2][MAX_INTERVALS];
   logic signed [31:0] en_ff [2][MAX_INTERVALS];
   logic               bank_ff, bank_in;
   logic [CW-1:0]      n_ff, n_in;

   logic [2:0]         state_ff, state_in;
   isu_pkg::req_type   op_ff;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      k_ff, k_in;
   logic signed [32:0] lo_ff, lo_in, hi_ff, hi_in;
   logic               placed_ff, placed_in;
   logic               hit_ff, hit_in, ovf_ff, ovf_in;
   logic [3:0]         hidx_ff, hidx_in;
   logic [31:0]        cnt_ff, cnt_in;
   logic               outv_ff, outv_in;
   isu_pkg::rsp_type   out_ff, out_in;

   logic               wr_en;
   logic [CW-1:0]      wr_idx;
   logic signed [31:0] wr_st, wr_en_v;
   logic signed [32:0] cur_st, cur_en;
   logic [IW-1:0]      ri;
   logic               in_rng;

   assign ri     = i_ff[IW-1:0];
   assign in_rng = (i_ff < n_ff);
   assign cur_st = in_rng ? 33'(st_ff[bank_ff][ri]) : 33'sd0;
   assign cur_en = in_rng ? 33'(en_ff[bank_ff][ri]) : 33'sd0;

   assign cmd_take  = (state_ff == ST_IDLE) && cmd_valid;
   assign rsp_empty = !outv_ff;
   assign rsp_data  = out_ff;

   // one stored interval per cycle through the sweep, except the revisit after a merged interval
   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      placed_in = placed_ff;
      hit_in    = hit_ff;
      hidx_in   = hidx_ff;
      ovf_in    = ovf_ff;
      cnt_in    = cnt_ff;
      bank_in   = bank_ff;
      n_in      = n_ff;
      outv_in   = outv_ff && !rsp_pop;
      out_in    = out_ff;
      wr_en     = 1'b0;
      wr_idx    = k_ff;
      wr_st     = lo_ff[31:0];
      wr_en_v   = hi_ff[31:0];
      unique case (state_ff)
         ST_IDLE: begin
            i_in      = '0;
            k_in      = '0;
            placed_in = 1'b0;
            hit_in    = 1'b0;
            hidx_in   = '0;
            ovf_in    = 1'b0;
            cnt_in    = '0;
            lo_in     = 33'(cmd_data.range_low);
            hi_in     = 33'(cmd_data.range_high);
            if (cmd_valid) begin
               if (cmd_data.mode == isu_pkg::MODE_INVERT) begin
                  // first gap starts at the bottom of the value range
                  lo_in = 33'(isu_pkg::VAL_MIN);
                  state_in = ST_SCAN;
               end else if (cmd_data.mode == isu_pkg::MODE_INCLUDE &&
                            cmd_data.range_high > cmd_data.range_low) begin
                  state_in = ST_SCAN;
               end else if (cmd_data.mode == isu_pkg::MODE_LOOKUP) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_STAT;
               end
            end
         end
         ST_SCAN: begin
            i_in = i_ff + CW'(1);
            case (op_ff.mode)
               isu_pkg::MODE_LOOKUP: begin
                  if (in_rng && !hit_ff && cur_st <= 33'(op_ff.probe_value) &&
                      33'(op_ff.probe_value) < cur_en) begin
                     hit_in  = 1'b1;
                     hidx_in = 4'(i_ff);
                  end
                  if (!in_rng) state_in = ST_STAT;
               end
               isu_pkg::MODE_INVERT: begin
                  if (in_rng) begin
                     // emit gap before this interval unless it is empty
                     if (cur_st != lo_ff) begin
                        wr_en   = 1'b1;
                        wr_st   = lo_ff[31:0];
                        wr_en_v = cur_st[31:0];
                        k_in    = k_ff + CW'(1);
                     end
                     lo_in = cur_en;
                  end else begin
                     if (lo_ff != 33'(isu_pkg::VAL_MAX)) begin
                        wr_en   = 1'b1;
                        wr_st   = lo_ff[31:0];
                        wr_en_v = isu_pkg::VAL_MAX;
                        k_in    = k_ff + CW'(1);
                     end
                     state_in = ST_STAT;
                  end
               end
               default: begin
                  if (in_rng && !placed_ff && cur_en < lo_ff) begin
                     wr_en   = 1'b1;
                     wr_st   = cur_st[31:0];
                     wr_en_v = cur_en[31:0];
                     k_in    = k_ff + CW'(1);
                  end else if (in_rng && !placed_ff && cur_st <= hi_ff) begin
                     if (cur_st < lo_ff) lo_in = cur_st;
                     if (cur_en > hi_ff) hi_in = cur_en;
                  end else if (!placed_ff) begin
                     // merged interval goes out, this entry is revisited
                     wr_en     = 1'b1;
                     k_in      = k_ff + CW'(1);
                     placed_in = 1'b1;
                     i_in      = i_ff;
                  end else if (in_rng) begin
                     wr_en   = 1'b1;
                     wr_st   = cur_st[31:0];
                     wr_en_v = cur_en[31:0];
                     k_in    = k_ff + CW'(1);
                  end else begin
                     state_in = ST_STAT;
                  end
               end
            endcase
            if (state_in == ST_STAT) begin
               i_in = '0;
               if (op_ff.mode != isu_pkg::MODE_LOOKUP) begin
                  if (k_in > CW'(MAX_INTERVALS)) begin
                     ovf_in = 1'b1;
                  end else begin
                     bank_in = ~bank_ff;
                     n_in    = k_in;
                  end
               end
            end
         end
         ST_STAT: begin
            // element count summed one interval a cycle
            if (in_rng) begin
               cnt_in = cnt_ff + 32'(cur_en - cur_st);
               i_in   = i_ff + CW'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!outv_in) begin
               out_in.hit            = hit_ff;
               out_in.hit_index      = hidx_ff;
               out_in.overflow       = ovf_ff;
               out_in.element_count  = cnt_ff;
               out_in.interval_count = 5'(n_ff);
               out_in.smallest       = (n_ff == '0) ? isu_pkg::VAL_MAX :
                                       st_ff[bank_ff][0];
               out_in.largest        = (n_ff == '0) ? isu_pkg::VAL_MIN :
                                       en_ff[bank_ff][IW'(n_ff - CW'(1))] - 32'sd1;
               outv_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // scratch bank write, entries past capacity are dropped
   always_ff @(posedge clock) begin
      if (wr_en && wr_idx < CW'(MAX_INTERVALS)) begin
         st_ff[~bank_ff][wr_idx[IW-1:0]] <= wr_st;
         en_ff[~bank_ff][wr_idx[IW-1:0]] <= wr_en_v;
      end
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         outv_ff  <= 1'b0;
         n_ff     <= '0;
         bank_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         outv_ff  <= outv_in;
         n_ff     <= n_in;
         bank_ff  <= bank_in;
      end
      if (cmd_take) op_ff <= cmd_data;
      i_ff      <= i_in;
      k_ff      <= k_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      placed_ff <= placed_in;
      hit_ff    <= hit_in;
      hidx_ff   <= hidx_in;
      ovf_ff    <= ovf_in;
      cnt_ff    <= cnt_in;
      out_ff    <= out_in;
   end

`ifndef SYNTHESIS
   a_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CW'(MAX_INTERVALS)) else $error("interval count above capacity");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (outv_ff && !rsp_pop) |=> outv_ff && $stable(out_ff))
      else $error("pending result changed");
   a_ovf_keep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STAT && ovf_ff) |-> $stable(n_ff))
      else $error("overflow altered the set");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> state_ff != ST_IDLE) else $error("request taken but idle");
`endif

endmodule
`default_nettype wire

### design/interval_set_union_top.sv
// top level of the interval set union block
//   channel   direction  handshake        payload
//   req       in         req_push/req_full isu_pkg::req_type
//   rsp       out        rsp_pop/rsp_empty isu_pkg::rsp_type
// push to result: the request waits in the queue, is taken while the engine is idle,
// goes through the sweep (skipped for an empty include or unused mode) and the count pass
// the engine reads one stored interval per cycle in the sweep, bar the revisit after
// a merged interval, and again in the element count pass; a result still waiting at the output holds it
// reset clears the set to empty; no memory clearing pass is needed
// two requests queue in front of the engine, one result waits at the output
`default_nettype none
module interval_set_union_top #(
   parameter int MAX_INTERVALS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire isu_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output isu_pkg::rsp_type      rsp_data
);

   logic             cmd_valid, cmd_take;
   isu_pkg::req_type cmd_data;

   isu_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_data(cmd_data)
   );

   isu_engine #(.MAX_INTERVALS(MAX_INTERVALS)) u_engine (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_data(cmd_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire
